>>> rtl/i128alu_pkg.sv
// opcode and compare-code constants for the 128-bit alu with divider
// no dependencies; imported by the top level
package i128alu_pkg;

	localparam int OPCODE_BITS = 5;
	localparam int IN_DATA_BITS = 264;
	localparam int OUT_DATA_BITS = 136;

	typedef logic [OPCODE_BITS-1:0] opcode_t;
	typedef logic [1:0] cmp_code_t;

	localparam opcode_t OP_ADD = 5'd0;
	localparam opcode_t OP_SUB = 5'd1;
	localparam opcode_t OP_AND = 5'd2;
	localparam opcode_t OP_OR = 5'd3;
	localparam opcode_t OP_XOR = 5'd4;
	localparam opcode_t OP_NOT = 5'd5;
	localparam opcode_t OP_NEG = 5'd6;
	localparam opcode_t OP_MUL = 5'd7;
	localparam opcode_t OP_SHL = 5'd8;
	localparam opcode_t OP_LSHR = 5'd9;
	localparam opcode_t OP_ASHR = 5'd10;
	localparam opcode_t OP_UCMP = 5'd11;
	localparam opcode_t OP_SCMP = 5'd12;
	localparam opcode_t OP_UDIV = 5'd13;
	localparam opcode_t OP_UREM = 5'd14;
	localparam opcode_t OP_SDIV = 5'd15;
	localparam opcode_t OP_SREM = 5'd16;
	localparam opcode_t OP_CLZ = 5'd17;
	localparam opcode_t OP_CTZ = 5'd18;
	localparam opcode_t OP_POPCNT = 5'd19;

	localparam cmp_code_t CMP_LT = 2'd0;
	localparam cmp_code_t CMP_EQ = 2'd1;
	localparam cmp_code_t CMP_GT = 2'd2;

endpackage

>>> rtl/int128_alu_with_divider.sv
// top level of the 128-bit alu with restoring divider: sequencer and registers
// depends on i128alu_pkg and i128alu_addsub
//
// usage:
//   s_* channel carries one operation per transaction (opcode and two operands),
//   m_* channel returns one result per transaction (result, compare code, flag).
//   s_tready is high only while the sequencer is idle; one operation is in
//   work at a time, and a new one may be taken while the last result waits.
// paths from acceptance to m_tvalid:
//   logic, add, sub, neg, compares, zero divisor, large shifts, unknown opcodes:
//   dispatch, then finish; shifts: one loop step per bit of the amount
//   mul, unsigned divide/remainder, popcount: one loop step per word bit
//   clz/ctz: loop steps until the first set bit or the end of the word
//   signed divide/remainder: as unsigned, with two operand negations and
//   one result negation
// the loops for mul, divide, popcount and clz/ctz use the one WORD_BITS-wide
// adder; every loop works one bit per cycle.
// reset clears the sequencer and m_tvalid. when m_tready is low the result
// holds in the output register and a finished operation waits for it.
module int128_alu_with_divider
	import i128alu_pkg::*;
#(
	parameter int WORD_BITS = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// opcode[4:0], a_hi[68:5], a_lo[132:69], b_hi[196:133], b_lo[260:197], zeros
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// result_hi[63:0], result_lo[127:64], cmp_result[129:128], div_by_zero[130], zeros
	output logic [OUT_DATA_BITS-1:0] m_tdata
);

	localparam int W = WORD_BITS;
	localparam int AW = $clog2(WORD_BITS);
	localparam int CW = $clog2(WORD_BITS + 1);
	localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] W_VAL = W'(WORD_BITS);
	localparam logic [CW-1:0] CNT_FULL = CW'(WORD_BITS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_NEGA = 3'd2;
	localparam logic [2:0] S_NEGB = 3'd3;
	localparam logic [2:0] S_RUN = 3'd4;
	localparam logic [2:0] S_POST = 3'd5;
	localparam logic [2:0] S_FIN = 3'd6;

	logic [2:0] state_q, state_d;
	opcode_t op_q, op_d;
	logic [W-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d, res_q, res_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic sa_q, sa_d, sb_q, sb_d;
	cmp_code_t cmp_q, cmp_d;
	logic dz_q, dz_d;
	logic m_valid_q, m_valid_d;
	logic [OUT_DATA_BITS-1:0] m_data_q, m_data_d;

	logic [W-1:0] add_x, add_y, add_sum;
	logic add_ci, add_co;
	logic [127:0] a_in128, b_in128, res128;
	logic [W-1:0] rem_sh, post_sel, cmp_flip;
	logic take, post_neg;

	i128alu_addsub #(.W(W)) u_addsub (
		.x  (add_x),
		.y  (add_y),
		.ci (add_ci),
		.sum(add_sum),
		.co (add_co)
	);

	assign a_in128 = {s_tdata[68:5], s_tdata[132:69]};
	assign b_in128 = {s_tdata[196:133], s_tdata[260:197]};
	assign res128 = 128'(res_q);
	assign rem_sh = {acc_q[W-2:0], a_q[W-1]};
	assign take = acc_q[W-1] | add_co;
	assign post_sel = (op_q == OP_SDIV) ? a_q : acc_q;
	assign post_neg = (op_q == OP_SDIV) ? (sa_q ^ sb_q) : sa_q;
	assign cmp_flip = (op_q == OP_SCMP) ? SIGN_BIT : '0;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		a_d = a_q;
		b_d = b_q;
		acc_d = acc_q;
		res_d = res_q;
		cnt_d = cnt_q;
		sa_d = sa_q;
		sb_d = sb_q;
		cmp_d = cmp_q;
		dz_d = dz_q;
		m_valid_d = m_valid_q & ~m_tready;
		m_data_d = m_data_q;
		add_x = '0;
		add_y = '0;
		add_ci = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_d = s_tdata[OPCODE_BITS-1:0];
					a_d = a_in128[W-1:0];
					b_d = b_in128[W-1:0];
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmp_d = CMP_LT;
				dz_d = 1'b0;
				res_d = '0;
				acc_d = '0;
				cnt_d = CNT_FULL;
				state_d = S_FIN;
				case (op_q)
					OP_ADD: begin
						add_x = a_q;
						add_y = b_q;
						res_d = add_sum;
					end
					OP_SUB: begin
						add_x = a_q;
						add_y = ~b_q;
						add_ci = 1'b1;
						res_d = add_sum;
					end
					OP_AND: res_d = a_q & b_q;
					OP_OR: res_d = a_q | b_q;
					OP_XOR: res_d = a_q ^ b_q;
					OP_NOT: res_d = ~a_q;
					OP_NEG: begin
						add_x = ~a_q;
						add_ci = 1'b1;
						res_d = add_sum;
					end
					OP_UCMP, OP_SCMP: begin
						// carry out of a - b means a >= b
						add_x = a_q ^ cmp_flip;
						add_y = ~(b_q ^ cmp_flip);
						add_ci = 1'b1;
						if (a_q == b_q) begin
							cmp_d = CMP_EQ;
						end else if (add_co) begin
							cmp_d = CMP_GT;
						end
					end
					OP_SHL, OP_LSHR, OP_ASHR: begin
						if (b_q >= W_VAL) begin
							res_d = (op_q == OP_ASHR && a_q[W-1]) ? '1 : '0;
						end else begin
							cnt_d = CW'(b_q[AW-1:0]);
							state_d = S_RUN;
						end
					end
					OP_MUL: state_d = S_RUN;
					OP_UDIV, OP_UREM, OP_SDIV, OP_SREM: begin
						if (b_q == '0) begin
							dz_d = 1'b1;
							res_d = (op_q == OP_UDIV || op_q == OP_SDIV) ? '1 : a_q;
						end else if (op_q == OP_SDIV || op_q == OP_SREM) begin
							sa_d = a_q[W-1];
							sb_d = b_q[W-1];
							state_d = S_NEGA;
						end else begin
							state_d = S_RUN;
						end
					end
					OP_CLZ, OP_CTZ, OP_POPCNT: state_d = S_RUN;
					default: state_d = S_FIN;
				endcase
			end
			S_NEGA: begin
				add_x = ~a_q;
				add_ci = 1'b1;
				if (sa_q) begin
					a_d = add_sum;
				end
				state_d = S_NEGB;
			end
			S_NEGB: begin
				add_x = ~b_q;
				add_ci = 1'b1;
				if (sb_q) begin
					b_d = add_sum;
				end
				state_d = S_RUN;
			end
			S_RUN: begin
				case (op_q)
					OP_SHL: begin
						if (cnt_q == '0) begin
							res_d = a_q;
							state_d = S_FIN;
						end else begin
							a_d = {a_q[W-2:0], 1'b0};
							cnt_d = cnt_q - 1'b1;
						end
					end
					OP_LSHR, OP_ASHR: begin
						if (cnt_q == '0) begin
							res_d = a_q;
							state_d = S_FIN;
						end else begin
							a_d = {(op_q == OP_ASHR) & a_q[W-1], a_q[W-1:1]};
							cnt_d = cnt_q - 1'b1;
						end
					end
					OP_MUL: begin
						// shift-add, low word of the product only
						add_x = acc_q;
						add_y = a_q;
						if (cnt_q == '0) begin
							res_d = acc_q;
							state_d = S_FIN;
						end else begin
							if (b_q[0]) begin
								acc_d = add_sum;
							end
							a_d = {a_q[W-2:0], 1'b0};
							b_d = {1'b0, b_q[W-1:1]};
							cnt_d = cnt_q - 1'b1;
						end
					end
					OP_UDIV, OP_UREM, OP_SDIV, OP_SREM: begin
						// restoring step: remainder in acc, dividend shifts out of a
						// while quotient bits shift in
						add_x = rem_sh;
						add_y = ~b_q;
						add_ci = 1'b1;
						if (cnt_q == '0) begin
							if (op_q == OP_UDIV) begin
								res_d = a_q;
								state_d = S_FIN;
							end else if (op_q == OP_UREM) begin
								res_d = acc_q;
								state_d = S_FIN;
							end else begin
								state_d = S_POST;
							end
						end else begin
							acc_d = take ? add_sum : rem_sh;
							a_d = {a_q[W-2:0], take};
							cnt_d = cnt_q - 1'b1;
						end
					end
					OP_POPCNT: begin
						add_x = acc_q;
						add_ci = a_q[0];
						if (cnt_q == '0) begin
							res_d = acc_q;
							state_d = S_FIN;
						end else begin
							acc_d = add_sum;
							a_d = {1'b0, a_q[W-1:1]};
							cnt_d = cnt_q - 1'b1;
						end
					end
					OP_CLZ: begin
						add_x = acc_q;
						add_ci = 1'b1;
						if (cnt_q == '0 || a_q[W-1]) begin
							res_d = acc_q;
							state_d = S_FIN;
						end else begin
							acc_d = add_sum;
							a_d = {a_q[W-2:0], 1'b0};
							cnt_d = cnt_q - 1'b1;
						end
					end
					OP_CTZ: begin
						add_x = acc_q;
						add_ci = 1'b1;
						if (cnt_q == '0 || a_q[0]) begin
							res_d = acc_q;
							state_d = S_FIN;
						end else begin
							acc_d = add_sum;
							a_d = {1'b0, a_q[W-1:1]};
							cnt_d = cnt_q - 1'b1;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_POST: begin
				// quotient sign is sa^sb, remainder sign follows the dividend
				add_x = ~post_sel;
				add_ci = 1'b1;
				res_d = post_neg ? add_sum : post_sel;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!m_valid_q || m_tready) begin
					m_valid_d = 1'b1;
					m_data_d = {5'b0, dz_q, cmp_q, res128[63:0], res128[127:64]};
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			m_valid_q <= m_valid_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		a_q <= a_d;
		b_q <= b_d;
		acc_q <= acc_d;
		res_q <= res_d;
		sa_q <= sa_d;
		sb_q <= sb_d;
		cmp_q <= cmp_d;
		dz_q <= dz_d;
		m_data_q <= m_data_d;
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("operation accepted while the sequencer was busy");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("step counter beyond word width");

	a_dz_no_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[130] |-> m_tdata[129:128] == CMP_LT)
		else $error("divide-by-zero result carries a compare code");
`endif

endmodule

>>> rtl/i128alu_addsub.sv
// shared adder of the alu: x + y + carry-in with carry-out
// no dependencies; instantiated once by the top level
module i128alu_addsub #(
	parameter int W = 128
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic         ci,
	output logic [W-1:0] sum,
	output logic         co
);

	assign {co, sum} = (W+1)'(x) + (W+1)'(y) + (W+1)'(ci);

endmodule

>>> sim/int128_alu_checker.sv
// checker for the 128-bit alu: watches both stream channels, predicts each result
// depends on i128alu_pkg for opcode and compare constants
module int128_alu_checker
	import i128alu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic         dz;
		logic [1:0]   cmp;
		logic [127:0] val;
	} alu_result_t;

	alu_result_t results_due[$];

	function automatic logic [7:0] count_ones(logic [127:0] x);
		logic [7:0] n;
		n = 0;
		for (int i = 0; i < 128; i++) n += x[i];
		return n;
	endfunction

	function automatic alu_result_t compute_alu(opcode_t op, logic [127:0] a, logic [127:0] b);
		alu_result_t r;
		logic [127:0] ma, mb, q, rm;
		logic signed [127:0] sh;
		logic big;
		int c;
		r = '0;
		big = (b >= 128);
		case (op)
			OP_ADD: r.val = a + b;
			OP_SUB: r.val = a - b;
			OP_AND: r.val = a & b;
			OP_OR: r.val = a | b;
			OP_XOR: r.val = a ^ b;
			OP_NOT: r.val = ~a;
			OP_NEG: r.val = -a;
			OP_MUL: r.val = a * b;
			OP_SHL: r.val = big ? '0 : a << b[6:0];
			OP_LSHR: r.val = big ? '0 : a >> b[6:0];
			OP_ASHR: begin
				sh = $signed(a) >>> b[6:0];
				r.val = big ? {128{a[127]}} : sh;
			end
			OP_UCMP: r.cmp = (a < b) ? CMP_LT : (a == b) ? CMP_EQ : CMP_GT;
			OP_SCMP: r.cmp = ($signed(a) < $signed(b)) ? CMP_LT :
				(a == b) ? CMP_EQ : CMP_GT;
			OP_UDIV, OP_UREM, OP_SDIV, OP_SREM: begin
				if (b == 0) begin
					r.dz = 1'b1;
					r.val = (op == OP_UDIV || op == OP_SDIV) ? '1 : a;
				end else if (op == OP_UDIV || op == OP_UREM) begin
					r.val = (op == OP_UDIV) ? a / b : a % b;
				end else begin
					ma = a[127] ? -a : a;
					mb = b[127] ? -b : b;
					q = ma / mb;
					rm = ma % mb;
					if (op == OP_SDIV) r.val = (a[127] ^ b[127]) ? -q : q;
					else r.val = a[127] ? -rm : rm;
				end
			end
			OP_CLZ: begin
				c = 128;
				for (int i = 0; i < 128; i++) if (a[i]) c = 127 - i;
				r.val = 128'(c);
			end
			OP_CTZ: begin
				c = 128;
				for (int i = 127; i >= 0; i--) if (a[i]) c = i;
				r.val = 128'(c);
			end
			OP_POPCNT: r.val = 128'(count_ones(a));
			default: ;
		endcase
		return r;
	endfunction

	assign pending = results_due.size();

	always @(posedge clk or negedge arst_n) begin
		alu_result_t e, got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				results_due.push_back(compute_alu(s_tdata[4:0],
					{s_tdata[68:5], s_tdata[132:69]}, {s_tdata[196:133], s_tdata[260:197]}));
			if (m_tvalid && m_tready) begin
				// result word sits high/low swapped in tdata
				got = {m_tdata[130], m_tdata[129:128], m_tdata[63:0], m_tdata[127:64]};
				if (results_due.size() == 0) begin
					$display("%t unexpected result transaction: actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					e = results_due.pop_front();
					if (got !== e) begin
						$display("%t mismatch: expected val %h cmp %0d dz %0b, actual val %h cmp %0d dz %0b",
							$time, e.val, e.cmp, e.dz, got.val, got.cmp, got.dz);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> sim/tb_int128_alu_with_divider.sv
// stimulus and verdict for the 128-bit alu with restoring divider
// depends on i128alu_pkg, int128_alu_with_divider and int128_alu_checker
module tb_int128_alu_with_divider;
	import i128alu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [IN_DATA_BITS-1:0] s_tdata = '0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	int fail_count, pending;
	logic calm = 0;

	localparam logic [127:0] MIN_NEG = {1'b1, 127'b0};

	always #6 clk = ~clk;

	int128_alu_with_divider u_dut (.*);
	int128_alu_checker u_chk (.*);

	function automatic logic [127:0] rand_wide();
		logic [127:0] v;
		int kind;
		v = {$urandom, $urandom, $urandom, $urandom};
		kind = $urandom_range(0, 9);
		case (kind)
			0: v = v >> $urandom_range(0, 127);
			1: v = 128'($urandom_range(0, 200));
			2: v = -128'($urandom_range(0, 5));
			3: v = MIN_NEG;
			4: v = 0;
			5: v = v << $urandom_range(0, 127);
			default: ;
		endcase
		return v;
	endfunction

	// valid stays up between back-to-back transactions, drops only while idling
	task automatic send_op(opcode_t op, logic [127:0] a, logic [127:0] b);
		while (!calm && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {3'b0, b[63:0], b[127:64], a[63:0], a[127:64], op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// result side stalls at random, never while calm is set
	always @(negedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 8);

	initial begin
		logic [127:0] a, b;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed corners
		send_op(OP_ADD, '1, 128'd1);
		send_op(OP_SUB, 0, 128'd1);
		send_op(OP_AND, '1, 128'h0f0f);
		send_op(OP_OR, MIN_NEG, 128'd1);
		send_op(OP_XOR, '1, '1);
		send_op(OP_NOT, 0, 0);
		send_op(OP_NEG, MIN_NEG, 0);
		send_op(OP_MUL, '1, '1);
		send_op(OP_SHL, '1, 128'd127);
		send_op(OP_SHL, '1, 128'd128);
		send_op(OP_LSHR, '1, {64'd1, 64'd0});
		send_op(OP_ASHR, MIN_NEG, 128'd200);
		send_op(OP_ASHR, MIN_NEG, 128'd127);
		send_op(OP_UCMP, '1, 0);
		send_op(OP_SCMP, '1, 0);
		send_op(OP_SCMP, MIN_NEG, MIN_NEG);
		send_op(OP_UDIV, 128'd5, 0);
		send_op(OP_UREM, 128'd5, 0);
		send_op(OP_SDIV, MIN_NEG, '1);
		send_op(OP_SREM, -128'd7, 128'd2);
		send_op(OP_SDIV, -128'd7, 0);
		send_op(OP_SREM, '1, 0);
		send_op(OP_CLZ, 0, 0);
		send_op(OP_CTZ, 0, 0);
		send_op(OP_POPCNT, '1, 0);
		send_op(opcode_t'(31), '1, '1);
		for (int i = 0; i < 1950; i++) begin
			calm = (i >= 800 && i < 1000);
			a = rand_wide();
			b = rand_wide();
			// upper bits of b mostly cleared, so shift amounts mostly stay below 256
			if ($urandom_range(0, 3) != 0) b[127:8] = ($urandom_range(0, 5) == 0) ? b[127:8] : '0;
			send_op(opcode_t'($urandom_range(0, 31) < 28 ? $urandom_range(0, 19)
				: $urandom_range(20, 31)), a, b);
		end
		s_tvalid <= 1'b0;
		calm = 1;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule

>>> filelist.f
rtl/i128alu_pkg.sv
rtl/i128alu_addsub.sv
rtl/int128_alu_with_divider.sv
sim/int128_alu_checker.sv
sim/tb_int128_alu_with_divider.sv
